@@ hw/rtl/ssp_pkg.sv @@
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared widths, constants, register indexes and control structs for the
// segment side point placer.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int CoordW = 27;
  localparam int DiffW  = 28;
  localparam int LenW   = 28;
  localparam int SqW    = 56;
  localparam int RootW  = 57;
  localparam int PitchW = 23;
  localparam int W2W    = 25;
  localparam int OpW    = 29;
  localparam int ProdW  = 58;
  localparam int OutW   = 32;
  localparam int CntW   = 6;
  localparam int IdxW   = 5;
  localparam int NumW   = 64;
  localparam int DenW   = 36;
  localparam int QuoW   = 30;
  localparam int ItW    = 5;
  localparam int CfgW   = 23;
  localparam int CfgIdxW = 2;

  localparam int SqrtIters   = 28;
  localparam int CntDivIters = 6;
  localparam int PtDivIters  = 30;

  localparam int MaxPointsDef = 32;
  localparam int MinLengthDef = 6554;

  localparam logic [PitchW-1:0] PitchRst  = 23'd65536;
  localparam logic [PitchW-1:0] OffsetRst = 23'd32768;
  localparam logic              DualRst   = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PITCH  = 2'd0,
    REG_OFFSET = 2'd1,
    REG_DUAL   = 2'd2
  } ssp_reg_t;

  typedef struct packed {
    logic load;
    logic sq1;
    logic sq2;
    logic sqrt_init;
    logic sqrt_step;
    logic round;
    logic cnt_start;
    logic cnt_fin;
    logic mul_dxl;
    logic mul_dyl;
    logic mul_tx;
    logic mul_ty;
    logic scale;
    logic pt_start;
    logic out_load;
    logic advance;
  } ssp_cmd_t;

  typedef struct packed {
    logic short_seg;
    logic cnt_direct;
    logic div_done;
    logic last;
  } ssp_stat_t;

endpackage

@@ hw/rtl/ssp_div.sv @@
// ----------------------------------------------------------------------------
// ssp_div
// Restoring divider, one quotient bit per cycle, for a run length given at
// start.
// ----------------------------------------------------------------------------
module ssp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ssp_pkg::NumW-1:0]   num,
  input  logic [ssp_pkg::DenW-1:0]   dvs,
  input  logic [ssp_pkg::ItW-1:0]    iters,
  output logic                       busy,
  output logic [ssp_pkg::QuoW-1:0]   quo
);
  import ssp_pkg::*;

  localparam int DsW = NumW + 2;

  logic [NumW-1:0] rem;
  logic [DsW-1:0]  ds;
  logic [ItW-1:0]  cnt;
  logic            ge;

  assign ge = {2'b00, rem} >= ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == ItW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      ds  <= DsW'(dvs) << (iters - ItW'(1));
      quo <= '0;
      cnt <= iters;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - ds[NumW-1:0];
      end
      quo <= {quo[QuoW-2:0], ge};
      ds  <= ds >> 1;
      cnt <= cnt - ItW'(1);
    end
  end

endmodule

@@ hw/rtl/ssp_datapath.sv @@
// ----------------------------------------------------------------------------
// ssp_datapath
// Registers, shared multiplier, square root step, dividers and output
// register of the point placer.
// ----------------------------------------------------------------------------
module ssp_datapath #(
  parameter int MAX_POINTS = ssp_pkg::MaxPointsDef,
  parameter int MIN_LENGTH = ssp_pkg::MinLengthDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ssp_pkg::ssp_cmd_t             cmd,
  output ssp_pkg::ssp_stat_t            stat,
  input  logic                          cfg_wr_en,
  input  logic [ssp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ssp_pkg::CfgW-1:0]      cfg_data,
  input  logic signed [ssp_pkg::CoordW-1:0] start_x,
  input  logic signed [ssp_pkg::CoordW-1:0] start_y,
  input  logic signed [ssp_pkg::CoordW-1:0] end_x,
  input  logic signed [ssp_pkg::CoordW-1:0] end_y,
  input  logic [ssp_pkg::PitchW-1:0]    seg_width,
  output logic signed [ssp_pkg::OutW-1:0] point_x,
  output logic signed [ssp_pkg::OutW-1:0] point_y,
  output logic                          side_neg,
  output logic                          count_clipped,
  output logic                          last_point
);
  import ssp_pkg::*;

  localparam logic [SqW-1:0] MinSq = SqW'(MIN_LENGTH) * SqW'(MIN_LENGTH);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_POINTS);

  logic [PitchW-1:0] pitch;
  logic [PitchW-1:0] offset;
  logic              dual;

  logic signed [CoordW-1:0] sx, sy;
  logic signed [DiffW-1:0]  dx, dy;
  logic [W2W-1:0]           w2;
  logic [SqW-1:0]           sq;
  logic [RootW-1:0]         rt_n, rt_r, rt_bit, rt_sum;
  logic [LenW-1:0]          len;
  logic                     pre_clip, clip;
  logic [CntW-1:0]          cnt, q6;
  logic [IdxW-1:0]          nm1, idx;
  logic signed [ProdW-1:0]  prod;
  logic signed [OpW-1:0]    op_a, op_b;
  logic signed [55:0]       dxl, dyl;
  logic signed [53:0]       tx, ty;
  logic signed [NumW-1:0]   ox, oy, accx, accy;
  logic [DenW-1:0]          den;
  logic                     side, negx, negy;
  logic [29:0]              cnt_num, cnt_lim;
  logic signed [NumW-1:0]   numx, numy;
  logic [NumW-1:0]          absx, absy, divnx, divny, div_num_x, div_num_y;
  logic [DenW-1:0]          div_dvs;
  logic [ItW-1:0]           div_it;
  logic                     div_start, busy_x, busy_y;
  logic [QuoW-1:0]          quo_x, quo_y;
  logic signed [59:0]       oxp, oyp;
  logic [33:0]              denp;
  logic signed [OutW-1:0]   qx, qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch  <= PitchRst;
      offset <= OffsetRst;
      dual   <= DualRst;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PITCH:  pitch  <= cfg_data;
        REG_OFFSET: offset <= cfg_data;
        REG_DUAL:   dual   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // One shared signed multiplier serves the squares, the length products and the width products.
  always_comb begin
    op_a = {dx[DiffW-1], dx};
    op_b = {dx[DiffW-1], dx};
    if (cmd.sq2) begin
      op_a = {dy[DiffW-1], dy};
      op_b = {dy[DiffW-1], dy};
    end else if (cmd.mul_dxl) begin
      op_b = {1'b0, len};
    end else if (cmd.mul_dyl) begin
      op_a = {dy[DiffW-1], dy};
      op_b = {1'b0, len};
    end else if (cmd.mul_tx) begin
      op_a = {dy[DiffW-1], dy};
      op_b = {4'b0, w2};
    end else if (cmd.mul_ty) begin
      op_b = {4'b0, w2};
    end
  end

  assign prod   = op_a * op_b;
  assign rt_sum = rt_r + rt_bit;
  assign nm1    = IdxW'(cnt - CntW'(1));
  assign oxp    = tx * $signed({1'b0, nm1});
  assign oyp    = ty * $signed({1'b0, nm1});
  assign denp   = {len, 1'b0} * nm1;

  assign cnt_num = 30'({len, 1'b0}) + 30'(pitch);
  assign cnt_lim = {pitch, 7'b0};
  assign q6      = quo_x[CntW-1:0];

  assign numx = side ? accx + ox : accx - ox;
  assign numy = side ? accy - oy : accy + oy;
  assign absx = numx[NumW-1] ? NumW'(-numx) : NumW'(numx);
  assign absy = numy[NumW-1] ? NumW'(-numy) : NumW'(numy);
  assign divnx = {absx[NumW-2:0], 1'b0} + NumW'(den);
  assign divny = {absy[NumW-2:0], 1'b0} + NumW'(den);

  always_comb begin
    div_start = cmd.cnt_start | cmd.pt_start;
    if (cmd.cnt_start) begin
      div_num_x = NumW'(cnt_num);
      div_num_y = NumW'(cnt_num);
      div_dvs   = DenW'({pitch, 1'b0});
      div_it    = ItW'(CntDivIters);
    end else begin
      div_num_x = divnx;
      div_num_y = divny;
      div_dvs   = {den[DenW-2:0], 1'b0};
      div_it    = ItW'(PtDivIters);
    end
  end

  ssp_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num_x), .dvs(div_dvs),
    .iters(div_it), .busy(busy_x), .quo(quo_x)
  );

  ssp_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num_y), .dvs(div_dvs),
    .iters(div_it), .busy(busy_y), .quo(quo_y)
  );

  assign qx = negx ? -OutW'(quo_x) : OutW'(quo_x);
  assign qy = negy ? -OutW'(quo_y) : OutW'(quo_y);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx <= start_x;
      sy <= start_y;
      dx <= DiffW'(end_x) - DiffW'(start_x);
      dy <= DiffW'(end_y) - DiffW'(start_y);
      w2 <= W2W'(seg_width) + {1'b0, offset, 1'b0};
    end
    if (cmd.sq1) sq <= prod[SqW-1:0];
    if (cmd.sq2) sq <= sq + prod[SqW-1:0];
    if (cmd.sqrt_init) begin
      rt_n   <= RootW'(sq);
      rt_r   <= '0;
      rt_bit <= RootW'(1) << 54;
    end
    if (cmd.sqrt_step) begin
      if (rt_n >= rt_sum) begin
        rt_n <= rt_n - rt_sum;
        rt_r <= (rt_r >> 1) + rt_bit;
      end else begin
        rt_r <= rt_r >> 1;
      end
      rt_bit <= rt_bit >> 2;
    end
    // Round the floor root up when the remainder exceeds the root.
    if (cmd.round) len <= rt_r[LenW-1:0] + LenW'(rt_n > rt_r);
    if (cmd.cnt_start) pre_clip <= (pitch == '0) || (cnt_num >= cnt_lim);
    if (cmd.cnt_fin) begin
      if (pre_clip || q6 > MaxCnt) begin
        cnt  <= MaxCnt;
        clip <= 1'b1;
      end else begin
        cnt  <= (q6 < CntW'(2)) ? CntW'(2) : q6;
        clip <= 1'b0;
      end
    end
    if (cmd.mul_dxl) dxl <= prod[55:0];
    if (cmd.mul_dyl) dyl <= prod[55:0];
    if (cmd.mul_tx)  tx  <= prod[53:0];
    if (cmd.mul_ty)  ty  <= prod[53:0];
    if (cmd.scale) begin
      ox   <= NumW'(oxp);
      oy   <= NumW'(oyp);
      den  <= DenW'(denp);
      idx  <= '0;
      side <= 1'b0;
      accx <= '0;
      accy <= '0;
    end
    if (cmd.pt_start) begin
      negx <= numx[NumW-1];
      negy <= numy[NumW-1];
    end
    if (cmd.out_load) begin
      point_x       <= OutW'(sx) + qx;
      point_y       <= OutW'(sy) + qy;
      side_neg      <= side;
      count_clipped <= clip;
      last_point    <= (idx == nm1) && (side || !dual);
    end
    if (cmd.advance) begin
      if (!side && dual) begin
        side <= 1'b1;
      end else begin
        side <= 1'b0;
        idx  <= idx + IdxW'(1);
        accx <= accx + NumW'($signed({dxl, 1'b0}));
        accy <= accy + NumW'($signed({dyl, 1'b0}));
      end
    end
  end

  assign stat.short_seg  = sq < MinSq;
  assign stat.cnt_direct = (pitch == '0) || (cnt_num >= cnt_lim);
  assign stat.div_done   = !busy_x && !busy_y;
  assign stat.last       = last_point;

endmodule

@@ hw/rtl/ssp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssp_ctrl
// Sequencer that steps the datapath through length, count, setup and the
// per-point divisions, and drives the channel handshakes.
// ----------------------------------------------------------------------------
module ssp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ssp_pkg::ssp_cmd_t  cmd,
  input  ssp_pkg::ssp_stat_t stat
);
  import ssp_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_SQ1   = 18'h00002,
    S_SQ2   = 18'h00004,
    S_CHK   = 18'h00008,
    S_SQRT  = 18'h00010,
    S_RND   = 18'h00020,
    S_CNT   = 18'h00040,
    S_CDIV  = 18'h00080,
    S_CFIN  = 18'h00100,
    S_M1    = 18'h00200,
    S_M2    = 18'h00400,
    S_M3    = 18'h00800,
    S_M4    = 18'h01000,
    S_SCALE = 18'h02000,
    S_PDIV  = 18'h04000,
    S_PWAIT = 18'h08000,
    S_POUT  = 18'h10000
  } state_t;

  state_t         state, state_next;
  logic [4:0]     step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQ1;
        end
      end
      S_SQ1: begin
        cmd.sq1    = 1'b1;
        state_next = S_SQ2;
      end
      S_SQ2: begin
        cmd.sq2    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.sqrt_init = 1'b1;
        step_next     = '0;
        state_next    = stat.short_seg ? S_IDLE : S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_next     = step + 5'd1;
        if (step == 5'(SqrtIters - 1)) state_next = S_RND;
      end
      S_RND: begin
        cmd.round  = 1'b1;
        state_next = S_CNT;
      end
      S_CNT: begin
        cmd.cnt_start = 1'b1;
        state_next    = stat.cnt_direct ? S_CFIN : S_CDIV;
      end
      S_CDIV: begin
        if (stat.div_done) state_next = S_CFIN;
      end
      S_CFIN: begin
        cmd.cnt_fin = 1'b1;
        state_next  = S_M1;
      end
      S_M1: begin
        cmd.mul_dxl = 1'b1;
        state_next  = S_M2;
      end
      S_M2: begin
        cmd.mul_dyl = 1'b1;
        state_next  = S_M3;
      end
      S_M3: begin
        cmd.mul_tx = 1'b1;
        state_next = S_M4;
      end
      S_M4: begin
        cmd.mul_ty = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_PDIV;
      end
      S_PDIV: begin
        cmd.pt_start = 1'b1;
        state_next   = S_PWAIT;
      end
      S_PWAIT: begin
        if (stat.div_done) begin
          cmd.out_load = 1'b1;
          state_next   = S_POUT;
        end
      end
      S_POUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_PDIV;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/segment_side_point_placer.sv @@
// ----------------------------------------------------------------------------
// segment_side_point_placer
// Places evenly spaced points beside a line segment, offset along its
// normal, with an optional mirrored point on the other side.
//
//   Channel  Signals                                  Direction
//   in       in_valid/in_ready, start_*, end_*, width  segment in
//   out      out_valid/out_ready, point_*, flags       point out
//   cfg      cfg_wr_en, cfg_index, cfg_data            register write
//
// After its transfer a segment runs through setup (squares, a 28-step
// square root, a count division, length and width products); the count
// division is skipped when the count saturates. Each result then comes from
// the 30-step divider pair and waits out any output stall. A short segment
// frees the input after its squares and the length check, with no setup.
// Reset is synchronous and returns the configuration registers to their defaults.
// A stalled output holds the sequencer; no new segment enters until the
// last point of the current one is transferred.
// ----------------------------------------------------------------------------
module segment_side_point_placer #(
  parameter int MAX_POINTS = ssp_pkg::MaxPointsDef,
  parameter int MIN_LENGTH = ssp_pkg::MinLengthDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ssp_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [ssp_pkg::CfgW-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ssp_pkg::CoordW-1:0] start_x,
  input  logic signed [ssp_pkg::CoordW-1:0] start_y,
  input  logic signed [ssp_pkg::CoordW-1:0] end_x,
  input  logic signed [ssp_pkg::CoordW-1:0] end_y,
  input  logic [ssp_pkg::PitchW-1:0]        seg_width,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ssp_pkg::OutW-1:0]   point_x,
  output logic signed [ssp_pkg::OutW-1:0]   point_y,
  output logic                              side_neg,
  output logic                              count_clipped,
  output logic                              last_point
);
  import ssp_pkg::*;

  ssp_cmd_t  cmd;
  ssp_stat_t stat;

  ssp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  ssp_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .MIN_LENGTH(MIN_LENGTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .seg_width(seg_width), .point_x(point_x), .point_y(point_y),
    .side_neg(side_neg), .count_clipped(count_clipped), .last_point(last_point)
  );

endmodule

@@ tb/segment_side_point_placer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_side_point_placer_tb
// Drives segments through the valid/ready input channel and checks every
// placed point against a behavioral predictor of the spacing and offset math.
// ----------------------------------------------------------------------------
module segment_side_point_placer_tb;
  import ssp_pkg::*;

  localparam int MaxPts    = 32;
  localparam int MinLen    = 6554;
  localparam int LimitCyc  = 8000000;
  localparam int SettleCyc = 200;

  typedef struct {
    logic signed [CoordW-1:0] sx, sy, ex, ey;
    logic [PitchW-1:0]        w;
  } segment_t;

  typedef struct {
    logic [OutW-1:0] x, y;
    logic            neg, clip, last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CoordW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [PitchW-1:0] seg_width = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OutW-1:0] point_x, point_y;
  logic side_neg, count_clipped, last_point;

  segment_side_point_placer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_t pending_segs[$];
  point_t   expected_pts[$];
  longint   pitch_r, offset_r;
  bit       dual_r;
  int       mismatches = 0;
  int       points_seen = 0;
  int       segs_sent = 0;
  bit       quiet = 1'b0;  // no idling on either side while set
  longint   cycles = 0;

  function automatic longint round_div(longint num, longint den);
    longint a, q;
    a = (num < 0) ? -num : num;
    q = (2 * a + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint int_root(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Appends the expected points of one segment under the current registers.
  task automatic predict_points(segment_t s);
    longint dx, dy, w2, sq, len, cnt, n, den, ax2, ay2, ox, oy;
    int total, k;
    bit clip;
    point_t p;
    dx = longint'(s.ex) - longint'(s.sx);
    dy = longint'(s.ey) - longint'(s.sy);
    w2 = longint'(s.w) + 2 * offset_r;
    sq = dx * dx + dy * dy;
    if (sq < longint'(MinLen) * MinLen) return;
    len = int_root(sq);
    if (len * len + len < sq) len++;
    clip = 1'b0;
    if (pitch_r == 0) begin
      cnt = MaxPts;
      clip = 1'b1;
    end else begin
      cnt = (2 * len + pitch_r) / (2 * pitch_r);
      if (cnt < 2) cnt = 2;
      if (cnt > MaxPts) begin
        cnt = MaxPts;
        clip = 1'b1;
      end
    end
    n = cnt - 1;
    den = 2 * n * len;
    total = int'(cnt) * (dual_r ? 2 : 1);
    k = 0;
    for (int i = 0; i < cnt; i++) begin
      ax2 = 2 * dx * i * len;
      ay2 = 2 * dy * i * len;
      ox = dy * w2 * n;
      oy = dx * w2 * n;
      p.x = OutW'(longint'(s.sx) + round_div(ax2 - ox, den));
      p.y = OutW'(longint'(s.sy) + round_div(ay2 + oy, den));
      p.neg = 1'b0; p.clip = clip; p.last = (k == total - 1);
      expected_pts.push_back(p);
      k++;
      if (dual_r) begin
        p.x = OutW'(longint'(s.sx) + round_div(ax2 + ox, den));
        p.y = OutW'(longint'(s.sy) + round_div(ay2 - oy, den));
        p.neg = 1'b1; p.last = (k == total - 1);
        expected_pts.push_back(p);
        k++;
      end
    end
  endtask

  // Driver: presents queued segments; prediction happens on transfer.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_points(pending_segs.pop_front());
        segs_sent <= segs_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_segs.size() != 0 && (quiet || $urandom_range(99) >= 24)) begin
          in_valid  <= 1'b1;
          start_x   <= pending_segs[0].sx;
          start_y   <= pending_segs[0].sy;
          end_x     <= pending_segs[0].ex;
          end_y     <= pending_segs[0].ey;
          seg_width <= pending_segs[0].w;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each transfer on the point channel.
  always @(posedge clk) begin
    point_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        points_seen <= points_seen + 1;
        if (expected_pts.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected point x=%h y=%h", point_x, point_y);
        end else begin
          e = expected_pts.pop_front();
          if (e.x !== point_x || e.y !== point_y || e.neg !== side_neg ||
              e.clip !== count_clipped || e.last !== last_point) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("point mismatch: exp x=%h y=%h n%b c%b l%b, got x=%h y=%h n%b c%b l%b",
                       e.x, e.y, e.neg, e.clip, e.last, point_x, point_y,
                       side_neg, count_clipped, last_point);
          end
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk) begin
    if (cycles > LimitCyc) begin
      $display("timeout with %0d points outstanding", expected_pts.size());
      $display("segment_side_point_placer verification failed");
      $finish;
    end
  end

  task automatic write_reg(ssp_reg_t idx, longint val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgW'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PITCH:  pitch_r = val & 64'h7FFFFF;
      REG_OFFSET: offset_r = val & 64'h7FFFFF;
      default:    dual_r = val[0];
    endcase
  endtask

  // Waits until every queued segment has been taken and all points arrived,
  // then lets a short segment finish inside the block.
  task automatic drain();
    while (pending_segs.size() != 0 || in_valid || expected_pts.size() != 0)
      @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  function automatic logic signed [CoordW-1:0] rnd_coord();
    return CoordW'($signed($urandom_range(131072000)) - 65536000);
  endfunction

  function automatic segment_t mk_seg(longint sx, sy, ex, ey, w);
    segment_t s;
    s.sx = CoordW'(sx); s.sy = CoordW'(sy); s.ex = CoordW'(ex); s.ey = CoordW'(ey);
    s.w = PitchW'(w);
    return s;
  endfunction

  // Mostly short segments so the point count stays moderate; some long ones.
  task automatic queue_random(int num);
    segment_t s;
    int span;
    for (int i = 0; i < num; i++) begin
      s.sx = rnd_coord();
      s.sy = rnd_coord();
      case ($urandom_range(9))
        0: begin s.ex = rnd_coord(); s.ey = rnd_coord(); end
        1: begin
          s.ex = s.sx + CoordW'($signed($urandom_range(12000)) - 6000);
          s.ey = s.sy + CoordW'($signed($urandom_range(12000)) - 6000);
        end
        2: begin s.ex = CoordW'($urandom); s.ey = CoordW'($urandom); end
        default: begin
          span = $urandom_range(1500000);
          s.ex = s.sx + CoordW'($signed($urandom_range(2 * span)) - span);
          s.ey = s.sy + CoordW'($signed($urandom_range(2 * span)) - span);
        end
      endcase
      s.w = ($urandom_range(7) == 0) ? PitchW'($urandom) : PitchW'($urandom_range(6553600));
      pending_segs.push_back(s);
    end
  endtask

  initial begin
    pitch_r = 65536; offset_r = 32768; dual_r = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, short and zero-length segments, diagonals.
    pending_segs.push_back(mk_seg(0, 0, 0, 0, 0));
    pending_segs.push_back(mk_seg(100, 100, 100 + 6553, 100, 0));
    pending_segs.push_back(mk_seg(0, 0, 6554, 0, 0));
    pending_segs.push_back(mk_seg(0, 0, 4634, 4634, 65536));
    pending_segs.push_back(mk_seg(-65536000, -65536000, 65536000, 65536000, 6553600));
    pending_segs.push_back(mk_seg(65536000, 0, -65536000, 0, 8388607));
    pending_segs.push_back(mk_seg(0, 65536000, 0, -65536000, 0));
    pending_segs.push_back(mk_seg(-67108864, -67108864, 67108863, 67108863, 8388607));
    pending_segs.push_back(mk_seg(0, 0, 196608, 131072, 1));
    pending_segs.push_back(mk_seg(1000, -2000, 1000 + 98304, -2000, 65536));
    pending_segs.push_back(mk_seg(0, 0, -327680, 327680, 131072));
    drain();

    write_reg(REG_PITCH, 0);
    write_reg(REG_OFFSET, 0);
    write_reg(REG_DUAL, 0);
    pending_segs.push_back(mk_seg(0, 0, 655360, 0, 0));
    pending_segs.push_back(mk_seg(5, 7, 5, 7 + 8000, 8388607));
    drain();
    write_reg(REG_PITCH, 8388607);
    write_reg(REG_OFFSET, 8388607);
    write_reg(REG_DUAL, 1);
    pending_segs.push_back(mk_seg(-65536000, 0, 65536000, 0, 8388607));
    pending_segs.push_back(mk_seg(0, 0, 20000, -30000, 0));
    drain();

    // Random phases under varied settings, one with no idling at all.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_PITCH, 65536); write_reg(REG_OFFSET, 32768); end
        1: begin write_reg(REG_PITCH, 1); write_reg(REG_DUAL, 0); end
        2: begin write_reg(REG_PITCH, $urandom_range(6553600, 1));
                 write_reg(REG_OFFSET, $urandom_range(6553600)); end
        3: begin quiet = 1'b1; write_reg(REG_PITCH, 200000); write_reg(REG_DUAL, 1); end
        4: begin quiet = 1'b0; write_reg(REG_PITCH, 6553600);
                 write_reg(REG_OFFSET, 6553600); end
        default: begin write_reg(REG_PITCH, $urandom_range(300000, 1));
                 write_reg(REG_OFFSET, $urandom); write_reg(REG_DUAL, $urandom); end
      endcase
      queue_random(48);
      drain();
    end

    $display("covered %0d segments and %0d points over several register settings",
             segs_sent, points_seen);
    if (mismatches == 0) begin
      $display("segment_side_point_placer verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("segment_side_point_placer verification failed");
    end
    $finish;
  end

endmodule
